[sv/current_autorange_scaler_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the current auto-range scaler
// Shared helpers that wrap concurrent assertions on clk with arst_n.
// ---------------------------------------------------------------------------
`ifndef CURRENT_AUTORANGE_SCALER_DEFINES_SVH
`define CURRENT_AUTORANGE_SCALER_DEFINES_SVH

// Assertion sampled on clk and switched off while reset is asserted.
`define CAR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Assertion sampled on clk that also holds while reset is asserted.
`define CAR_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/car_pkg.sv]
// ---------------------------------------------------------------------------
// Current auto-range scaler package
// Shared types, widths and reset values for the scaler and its sub-blocks.
// ---------------------------------------------------------------------------
package car_pkg;

	// Converter resolution and the derived midscale of a current code.
	localparam int ADC_BITS = 12;
	localparam logic [ADC_BITS-1:0] MIDSCALE = ADC_BITS'(1 << (ADC_BITS - 1));

	// Result widths.
	localparam int VOLT_W = 28;
	localparam int CUR_W  = 36;
	localparam int FRAC_SHIFT = 8;

	// Configuration port widths.
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// Shunt ranges.
	typedef enum logic [1:0] {
		RANGE_LOW  = 2'd0,
		RANGE_MID  = 2'd1,
		RANGE_HIGH = 2'd2
	} range_t;

	// Register indexes on the configuration port.
	typedef enum logic [2:0] {
		REG_TRUST_MAX   = 3'd0,
		REG_OVER_THR    = 3'd1,
		REG_UNDER_THR   = 3'd2,
		REG_HOLD_COUNT  = 3'd3,
		REG_VOLT_GAIN   = 3'd4,
		REG_GAIN_LOW    = 3'd5,
		REG_GAIN_MID    = 3'd6,
		REG_GAIN_HIGH   = 3'd7
	} reg_idx_t;

	// Reset values of the configuration registers.
	localparam logic [ADC_BITS-1:0] TRUST_MAX_RST  = ADC_BITS'(4000);
	localparam logic [ADC_BITS-1:0] OVER_THR_RST   = ADC_BITS'(1900);
	localparam logic [ADC_BITS-1:0] UNDER_THR_RST  = ADC_BITS'(18);
	localparam logic [3:0]          HOLD_COUNT_RST = 4'd8;
	localparam logic [23:0]         VOLT_GAIN_RST  = 24'd528000;
	localparam logic [31:0]         GAIN_RST       = 32'd65536;

	// Configuration as seen by the datapath.
	typedef struct packed {
		logic [ADC_BITS-1:0] trust_max;
		logic [ADC_BITS-1:0] over_threshold;
		logic [ADC_BITS-1:0] under_threshold;
		logic [3:0]          hold_count;
		logic [23:0]         voltage_gain;
		logic [31:0]         gain_low;
		logic [31:0]         gain_mid;
		logic [31:0]         gain_high;
	} cfg_t;

	// Range decision for the sample currently in the input stage.
	typedef struct packed {
		logic                trusted;
		range_t              range;
		logic [ADC_BITS-1:0] code;
		logic [1:0]          next_range;
	} range_info_t;

endpackage

[sv/current_autorange_scaler.sv]
// ---------------------------------------------------------------------------
// Current auto-range scaler
// Picks the shunt range per sample with hysteresis and scales voltage and
// signed current to fixed-point values.
// ---------------------------------------------------------------------------
// Usage:
// A sample (one voltage code and three current codes) is offered on the input
// channel with in_valid/in_ready; one result per sample leaves on the output
// channel with out_valid/out_ready. Each request passes an input register and
// a result register: out_valid rises when the request moves from the input
// register into the result register, which can wait on a stalled result.
// Throughput is one sample per cycle unless the receiver stalls: the input
// register hands on to the result register in the same cycle that it takes
// a new sample; the two multipliers (12x24 voltage, 13x33 current) bound it.
// The range and hysteresis counters update as a sample moves into the result
// register, so every sample sees the range left by the one before it.
// When the receiver stalls, the result register holds and the input register
// takes one more sample; after that in_ready falls until the result is taken.
// Reset empties both registers, sets the high range, clears the counters and
// loads the register defaults; pready is always high. Registers must be written
// over the APB-style port only while no sample is in flight; not enforced.
// ---------------------------------------------------------------------------
`include "current_autorange_scaler_defines.svh"

module current_autorange_scaler (
	input  logic                          clk,
	input  logic                          arst_n,
	// Sample channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [car_pkg::ADC_BITS-1:0]  voltage_code,
	input  logic [car_pkg::ADC_BITS-1:0]  low_code,
	input  logic [car_pkg::ADC_BITS-1:0]  mid_code,
	input  logic [car_pkg::ADC_BITS-1:0]  high_code,
	// Result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          trusted,
	output logic [1:0]                    sample_range,
	output logic [car_pkg::VOLT_W-1:0]    voltage_value,
	output logic signed [car_pkg::CUR_W-1:0] current_value,
	output logic                          route_en1,
	output logic                          route_en2,
	// Configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [car_pkg::ADDR_W-1:0]    paddr,
	input  logic [car_pkg::DATA_W-1:0]    pwdata,
	output logic [car_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	localparam int VPROD_W = car_pkg::ADC_BITS + 24;
	localparam int CPROD_W = car_pkg::ADC_BITS + 34;

	car_pkg::cfg_t                cfg;
	car_pkg::range_info_t         info;

	logic                         valid_s1;
	logic [car_pkg::ADC_BITS-1:0] vcode_s1;
	logic [car_pkg::ADC_BITS-1:0] low_s1;
	logic [car_pkg::ADC_BITS-1:0] mid_s1;
	logic [car_pkg::ADC_BITS-1:0] high_s1;

	logic                         valid_s2;
	logic                         trusted_s2;
	logic [1:0]                   range_s2;
	logic [car_pkg::VOLT_W-1:0]   volt_s2;
	logic [car_pkg::CUR_W-1:0]    cur_s2;
	logic                         en1_s2;
	logic                         en2_s2;

	logic                         advance;
	logic [31:0]                  gain;
	logic [VPROD_W-1:0]           vprod;
	logic signed [car_pkg::ADC_BITS:0] sdiff;
	logic signed [32:0]           sgain;
	logic signed [CPROD_W-1:0]    cprod;

	// Configuration registers.
	car_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Handshake: the input stage moves on whenever the result register is free.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			vcode_s1 <= voltage_code;
			low_s1   <= low_code;
			mid_s1   <= mid_code;
			high_s1  <= high_code;
		end
	end

	// Range selection and hysteresis state.
	car_range u_range (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.cfg       (cfg),
		.low_code  (low_s1),
		.mid_code  (mid_s1),
		.high_code (high_s1),
		.info      (info)
	);

	// Gain of the range in use.
	always_comb begin
		case (info.range)
			car_pkg::RANGE_LOW: gain = cfg.gain_low;
			car_pkg::RANGE_MID: gain = cfg.gain_mid;
			default:            gain = cfg.gain_high;
		endcase
	end

	// Scaling: the arithmetic shift of the signed product rounds to minus infinity.
	assign vprod = VPROD_W'(vcode_s1) * VPROD_W'(cfg.voltage_gain);
	assign sdiff = $signed({1'b0, info.code}) - $signed({1'b0, car_pkg::MIDSCALE});
	assign sgain = $signed({1'b0, gain});
	assign cprod = CPROD_W'(sdiff) * CPROD_W'(sgain);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			trusted_s2 <= info.trusted;
			range_s2   <= info.range;
			volt_s2    <= info.trusted
				? vprod[car_pkg::FRAC_SHIFT +: car_pkg::VOLT_W] : '0;
			cur_s2     <= info.trusted
				? cprod[car_pkg::FRAC_SHIFT +: car_pkg::CUR_W] : '0;
			en1_s2     <= info.next_range == car_pkg::RANGE_HIGH;
			en2_s2     <= info.next_range == car_pkg::RANGE_MID;
		end
	end

	assign out_valid     = valid_s2;
	assign trusted       = trusted_s2;
	assign sample_range  = range_s2;
	assign voltage_value = volt_s2;
	assign current_value = $signed(cur_s2);
	assign route_en1     = en1_s2;
	assign route_en2     = en2_s2;

	// With the result register empty the block always takes a new request.
	`CAR_ASSERT(a_ready_when_empty, !valid_s2 |-> in_ready, "not ready with empty output")

	// An untrusted result carries no measurement.
	`CAR_ASSERT(a_untrusted_zero, valid_s2 && !trusted_s2 |-> (volt_s2 == '0) && (cur_s2 == '0), "untrusted result not zero")

endmodule

[sv/car_cfg.sv]
// ---------------------------------------------------------------------------
// Configuration register file
// APB-style register bank holding thresholds and gains of the scaler.
// ---------------------------------------------------------------------------
module car_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [car_pkg::ADDR_W-1:0]  paddr,
	input  logic [car_pkg::DATA_W-1:0]  pwdata,
	output logic [car_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output car_pkg::cfg_t               cfg
);

	car_pkg::cfg_t    cfg_q;
	car_pkg::reg_idx_t idx;
	logic             wr_en;

	assign pready = 1'b1;
	assign idx    = car_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trust_max       <= car_pkg::TRUST_MAX_RST;
			cfg_q.over_threshold  <= car_pkg::OVER_THR_RST;
			cfg_q.under_threshold <= car_pkg::UNDER_THR_RST;
			cfg_q.hold_count      <= car_pkg::HOLD_COUNT_RST;
			cfg_q.voltage_gain    <= car_pkg::VOLT_GAIN_RST;
			cfg_q.gain_low        <= car_pkg::GAIN_RST;
			cfg_q.gain_mid        <= car_pkg::GAIN_RST;
			cfg_q.gain_high       <= car_pkg::GAIN_RST;
		end else if (wr_en) begin
			case (idx)
				car_pkg::REG_TRUST_MAX: begin
					cfg_q.trust_max <= pwdata[car_pkg::ADC_BITS-1:0];
				end
				car_pkg::REG_OVER_THR: begin
					cfg_q.over_threshold <= pwdata[car_pkg::ADC_BITS-1:0];
				end
				car_pkg::REG_UNDER_THR: begin
					cfg_q.under_threshold <= pwdata[car_pkg::ADC_BITS-1:0];
				end
				car_pkg::REG_HOLD_COUNT: begin
					cfg_q.hold_count <= pwdata[3:0];
				end
				car_pkg::REG_VOLT_GAIN: begin
					cfg_q.voltage_gain <= pwdata[23:0];
				end
				car_pkg::REG_GAIN_LOW: begin
					cfg_q.gain_low <= pwdata;
				end
				car_pkg::REG_GAIN_MID: begin
					cfg_q.gain_mid <= pwdata;
				end
				car_pkg::REG_GAIN_HIGH: begin
					cfg_q.gain_high <= pwdata;
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// Read-back multiplexer.
	always_comb begin
		prdata = '0;
		case (idx)
			car_pkg::REG_TRUST_MAX:  prdata = car_pkg::DATA_W'(cfg_q.trust_max);
			car_pkg::REG_OVER_THR:   prdata = car_pkg::DATA_W'(cfg_q.over_threshold);
			car_pkg::REG_UNDER_THR:  prdata = car_pkg::DATA_W'(cfg_q.under_threshold);
			car_pkg::REG_HOLD_COUNT: prdata = car_pkg::DATA_W'(cfg_q.hold_count);
			car_pkg::REG_VOLT_GAIN:  prdata = car_pkg::DATA_W'(cfg_q.voltage_gain);
			car_pkg::REG_GAIN_LOW:   prdata = cfg_q.gain_low;
			car_pkg::REG_GAIN_MID:   prdata = cfg_q.gain_mid;
			car_pkg::REG_GAIN_HIGH:  prdata = cfg_q.gain_high;
			default:                 prdata = '0;
		endcase
	end

endmodule

[sv/car_range.sv]
// ---------------------------------------------------------------------------
// Range selection and hysteresis
// Holds the active range and the over/under counters, picks the code of the
// active range and decides the range for the next sample.
// ---------------------------------------------------------------------------
`include "current_autorange_scaler_defines.svh"

module car_range (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  car_pkg::cfg_t                 cfg,
	input  logic [car_pkg::ADC_BITS-1:0]  low_code,
	input  logic [car_pkg::ADC_BITS-1:0]  mid_code,
	input  logic [car_pkg::ADC_BITS-1:0]  high_code,
	output car_pkg::range_info_t          info
);

	logic [1:0]                   range_q;
	logic [3:0]                   over_q;
	logic [3:0]                   under_q;
	logic [1:0]                   range_d;
	logic [3:0]                   over_d;
	logic [3:0]                   under_d;
	car_pkg::range_t              rng;
	logic [car_pkg::ADC_BITS-1:0] code;
	logic [car_pkg::ADC_BITS-1:0] diff;
	logic                         trusted;
	logic                         over_hit;
	logic                         under_hit;
	logic [3:0]                   over_inc;
	logic [3:0]                   under_inc;
	logic [1:0]                   rng_up;
	logic [1:0]                   rng_down;

	// Effective range; the unused code is treated as the high range.
	always_comb begin
		case (range_q)
			car_pkg::RANGE_LOW: begin
				rng  = car_pkg::RANGE_LOW;
				code = low_code;
			end
			car_pkg::RANGE_MID: begin
				rng  = car_pkg::RANGE_MID;
				code = mid_code;
			end
			default: begin
				rng  = car_pkg::RANGE_HIGH;
				code = high_code;
			end
		endcase
	end

	// Trust check and distance from midscale.
	assign trusted   = code < cfg.trust_max;
	assign diff      = (code >= car_pkg::MIDSCALE) ? (code - car_pkg::MIDSCALE)
	                                               : (car_pkg::MIDSCALE - code);
	assign over_hit  = diff > cfg.over_threshold;
	assign under_hit = diff < cfg.under_threshold;
	assign over_inc  = over_q + 4'd1;
	assign under_inc = under_q + 4'd1;

	// Saturating range steps.
	assign rng_up   = (rng == car_pkg::RANGE_HIGH) ? car_pkg::RANGE_HIGH : rng + 2'd1;
	assign rng_down = (rng == car_pkg::RANGE_LOW) ? car_pkg::RANGE_LOW : rng - 2'd1;

	// Hysteresis update for the sample in flight.
	always_comb begin
		range_d = range_q;
		over_d  = over_q;
		under_d = under_q;
		if (!trusted) begin
			range_d = rng_up;
		end else if (over_hit) begin
			under_d = '0;
			if (over_inc >= cfg.hold_count) begin
				over_d  = '0;
				range_d = rng_up;
			end else begin
				over_d = over_inc;
			end
		end else if (under_hit) begin
			over_d = '0;
			if (under_inc >= cfg.hold_count) begin
				under_d = '0;
				range_d = rng_down;
			end else begin
				under_d = under_inc;
			end
		end else begin
			over_d  = '0;
			under_d = '0;
		end
	end

	// State registers advance once per sample handed on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= car_pkg::RANGE_HIGH;
			over_q  <= '0;
			under_q <= '0;
		end else if (step) begin
			range_q <= range_d;
			over_q  <= over_d;
			under_q <= under_d;
		end
	end

	assign info.trusted    = trusted;
	assign info.range      = rng;
	assign info.code       = code;
	assign info.next_range = range_d;

	// The two hysteresis counters are never both running.
	`CAR_ASSERT(a_counters_exclusive, !((over_q != 4'd0) && (under_q != 4'd0)), "both counters set")

	// Range and counters hold while no sample is handed on.
	`CAR_ASSERT(a_state_holds, !step |=> $stable(range_q) && $stable(over_q) && $stable(under_q), "state moved without a sample")

	// An untrusted sample below the high range always moves the range up.
	`CAR_ASSERT(a_untrusted_up, step && !trusted && (rng != car_pkg::RANGE_HIGH) |=> range_q != $past(range_q), "untrusted sample kept the range")

endmodule

[test/autorange_checker.sv]
// ---------------------------------------------------------------------------
// Auto-range scaler checker
// Watches the sample, result and register ports of the current auto-range
// scaler. It keeps its own copy of the range, the hysteresis counters and the
// register settings, predicts the reading for every accepted request, and
// compares each delivered result, field by field, with the oldest prediction.
// Register reads are compared with the settings last written.
// ---------------------------------------------------------------------------
module autorange_checker import car_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [ADC_BITS-1:0] voltage_code,
	input  logic [ADC_BITS-1:0] low_code,
	input  logic [ADC_BITS-1:0] mid_code,
	input  logic [ADC_BITS-1:0] high_code,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic                trusted,
	input  logic [1:0]          sample_range,
	input  logic [VOLT_W-1:0]   voltage_value,
	input  logic [CUR_W-1:0]    current_value,
	input  logic                route_en1,
	input  logic                route_en2,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	input  logic [DATA_W-1:0]   prdata,
	input  logic                pready,
	output int                  pending,
	output int                  failures
);

	// One predicted reading, laid out as the result port.
	typedef struct packed {
		logic              trusted;
		logic [1:0]        sample_range;
		logic [VOLT_W-1:0] voltage_value;
		logic [CUR_W-1:0]  current_value;
		logic              route_en1;
		logic              route_en2;
	} reading_t;

	// Settings, range and hysteresis counters as the block should hold them.
	cfg_t       cfg;
	range_t     active;
	logic [3:0] over_run;
	logic [3:0] under_run;

	reading_t        expected_readings[$];
	reading_t        oldest;
	reg_idx_t        reg_sel;
	logic [DATA_W-1:0] reg_now;
	int              mismatches = 0;

	function automatic range_t step_up(range_t r);
		return (r == RANGE_LOW) ? RANGE_MID : RANGE_HIGH;
	endfunction

	// Works out the reading for one sample and moves the range and the
	// counters on, exactly as the block is meant to.
	function automatic reading_t scale_sample(logic [ADC_BITS-1:0] v, l, m, h);
		reading_t            res;
		range_t              rng;
		logic [ADC_BITS-1:0] code;
		logic [31:0]         gain;
		logic [ADC_BITS-1:0] delta;
		logic [63:0]         prod;
		logic [CUR_W-1:0]    mag;
		rng = active;
		case (rng)
		RANGE_LOW: begin
			code = l;
			gain = cfg.gain_low;
		end
		RANGE_MID: begin
			code = m;
			gain = cfg.gain_mid;
		end
		default: begin
			code = h;
			gain = cfg.gain_high;
		end
		endcase
		res = '0;
		res.trusted = (code < cfg.trust_max);
		res.sample_range = rng;
		if (res.trusted) begin
			prod = 64'(v) * 64'(cfg.voltage_gain);
			res.voltage_value = prod[FRAC_SHIFT +: VOLT_W];
			// Below midscale the magnitude is rounded up, so the signed
			// value rounds towards minus infinity.
			if (code >= MIDSCALE) begin
				delta = code - MIDSCALE;
				prod = 64'(delta) * 64'(gain);
				res.current_value = prod[FRAC_SHIFT +: CUR_W];
			end else begin
				delta = MIDSCALE - code;
				prod = 64'(delta) * 64'(gain) + 64'd255;
				mag = prod[FRAC_SHIFT +: CUR_W];
				res.current_value = -mag;
			end
			// Hysteresis: a run of hits steps the range, anything else
			// clears both runs.
			if (delta > cfg.over_threshold) begin
				over_run = over_run + 4'd1;
				under_run = '0;
				if (over_run >= cfg.hold_count) begin
					over_run = '0;
					active = step_up(rng);
				end
			end else if (delta < cfg.under_threshold) begin
				under_run = under_run + 4'd1;
				over_run = '0;
				if (under_run >= cfg.hold_count) begin
					under_run = '0;
					active = (rng == RANGE_HIGH) ? RANGE_MID : RANGE_LOW;
				end
			end else begin
				over_run = '0;
				under_run = '0;
			end
		end else begin
			// An untrusted sample steps up at once and leaves the runs alone.
			active = step_up(rng);
		end
		res.route_en1 = (active == RANGE_HIGH);
		res.route_en2 = (active == RANGE_MID);
		return res;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 200) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg = '{trust_max: TRUST_MAX_RST, over_threshold: OVER_THR_RST,
				under_threshold: UNDER_THR_RST, hold_count: HOLD_COUNT_RST,
				voltage_gain: VOLT_GAIN_RST, gain_low: GAIN_RST, gain_mid: GAIN_RST,
				gain_high: GAIN_RST};
			active = RANGE_HIGH;
			over_run = '0;
			under_run = '0;
			expected_readings.delete();
			pending <= 0;
		end else begin
			// Register port: follow writes, compare reads.
			if (psel && penable && pready) begin
				reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);
				case (reg_sel)
				REG_TRUST_MAX:  reg_now = DATA_W'(cfg.trust_max);
				REG_OVER_THR:   reg_now = DATA_W'(cfg.over_threshold);
				REG_UNDER_THR:  reg_now = DATA_W'(cfg.under_threshold);
				REG_HOLD_COUNT: reg_now = DATA_W'(cfg.hold_count);
				REG_VOLT_GAIN:  reg_now = DATA_W'(cfg.voltage_gain);
				REG_GAIN_LOW:   reg_now = cfg.gain_low;
				REG_GAIN_MID:   reg_now = cfg.gain_mid;
				default:        reg_now = cfg.gain_high;
				endcase
				if (pwrite) begin
					case (reg_sel)
					REG_TRUST_MAX:  cfg.trust_max = pwdata[ADC_BITS-1:0];
					REG_OVER_THR:   cfg.over_threshold = pwdata[ADC_BITS-1:0];
					REG_UNDER_THR:  cfg.under_threshold = pwdata[ADC_BITS-1:0];
					REG_HOLD_COUNT: cfg.hold_count = pwdata[3:0];
					REG_VOLT_GAIN:  cfg.voltage_gain = pwdata[23:0];
					REG_GAIN_LOW:   cfg.gain_low = pwdata;
					REG_GAIN_MID:   cfg.gain_mid = pwdata;
					default:        cfg.gain_high = pwdata;
					endcase
				end else begin
					check_field("prdata", 64'(reg_now), 64'(prdata));
				end
			end

			// Result channel: compare with the oldest prediction.
			if (out_valid && out_ready) begin
				if (expected_readings.size() == 0) begin
					mismatches++;
					$display("%0t: result delivered with no request outstanding", $time);
				end else begin
					oldest = expected_readings.pop_front();
					check_field("trusted", 64'(oldest.trusted), 64'(trusted));
					check_field("sample_range", 64'(oldest.sample_range), 64'(sample_range));
					check_field("voltage_value", 64'(oldest.voltage_value),
						64'(voltage_value));
					check_field("current_value", 64'(oldest.current_value),
						64'(current_value));
					check_field("route_en1", 64'(oldest.route_en1), 64'(route_en1));
					check_field("route_en2", 64'(oldest.route_en2), 64'(route_en2));
				end
			end

			// Sample channel: predict the reading of each accepted request.
			if (in_valid && in_ready) begin
				expected_readings.push_back(scale_sample(voltage_code, low_code, mid_code,
					high_code));
			end

			pending <= expected_readings.size();
			failures <= mismatches;
		end
	end

endmodule

[test/current_autorange_scaler_tb.sv]
// ---------------------------------------------------------------------------
// Current auto-range scaler testbench
// Drives samples and register settings into the scaler with random gaps on
// both channels and leaves the checking to the checker beside it. A short
// directed run covers the code extremes, trust limits, range stepping at
// both ends and extreme gains; random phases then follow with fresh
// settings, trends of near-midscale and far-off codes, a long receiver
// hold-off and a full drain in mid-phase.
// ---------------------------------------------------------------------------
module current_autorange_scaler_tb;
	import car_pkg::*;

	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_PHASES   = 6;
	localparam int PHASE_REQUESTS  = 180;

	// Shape of the current codes in a run of requests.
	typedef enum {TREND_NEAR, TREND_FAR, TREND_ANY} trend_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [ADC_BITS-1:0]        voltage_code = '0;
	logic [ADC_BITS-1:0]        low_code = '0;
	logic [ADC_BITS-1:0]        mid_code = '0;
	logic [ADC_BITS-1:0]        high_code = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic                       trusted;
	logic [1:0]                 sample_range;
	logic [VOLT_W-1:0]          voltage_value;
	logic signed [CUR_W-1:0]    current_value;
	logic                       route_en1;
	logic                       route_en2;
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [ADDR_W-1:0]          paddr = '0;
	logic [DATA_W-1:0]          pwdata = '0;
	logic [DATA_W-1:0]          prdata;
	logic                       pready;
	int                         pending;
	int                         failures;
	logic                       hold_off_req = 1'b0;
	int unsigned                cycle_count = 0;

	current_autorange_scaler dut (.*);

	autorange_checker checker_i (.*);

	// Clock, period 8.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Guard against a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: cycle limit reached with %0d results outstanding", $time, pending);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Mostly no gap, sometimes a short one, now and then a long one.
	function automatic int rand_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) return 0;
		if (pick < 88) return $urandom_range(1, 3);
		if (pick < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [ADC_BITS-1:0] shape_code(trend_t t);
		case (t)
		TREND_NEAR: return ADC_BITS'(2018 + $urandom_range(0, 60));
		TREND_FAR: begin
			if ($urandom_range(0, 1) == 0) return ADC_BITS'($urandom_range(0, 150));
			return ADC_BITS'($urandom_range(3945, 4095));
		end
		default: return ADC_BITS'($urandom_range(0, 4095));
		endcase
	endfunction

	// Offers one request and holds it until accepted; the valid stays high
	// when the next request follows with no gap.
	task automatic send_sample(input logic [ADC_BITS-1:0] v, l, m, h, input int gap);
		in_valid <= 1'b1;
		voltage_code <= v;
		low_code <= l;
		mid_code <= m;
		high_code <= h;
		do @(posedge clk); while (!in_ready);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops offering and waits until every result has been delivered.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// One register transfer: setup cycle, then access until pready.
	task automatic apb_access(input logic wr, input reg_idx_t r, input logic [DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {r, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// Writes every register, then reads each back for the checker.
	task automatic apply_settings(input cfg_t s);
		logic [DATA_W-1:0] val;
		for (int i = REG_TRUST_MAX; i <= REG_GAIN_HIGH; i++) begin
			case (reg_idx_t'(i))
			REG_TRUST_MAX:  val = DATA_W'(s.trust_max);
			REG_OVER_THR:   val = DATA_W'(s.over_threshold);
			REG_UNDER_THR:  val = DATA_W'(s.under_threshold);
			REG_HOLD_COUNT: val = DATA_W'(s.hold_count);
			REG_VOLT_GAIN:  val = DATA_W'(s.voltage_gain);
			REG_GAIN_LOW:   val = s.gain_low;
			REG_GAIN_MID:   val = s.gain_mid;
			default:        val = s.gain_high;
			endcase
			apb_access(1'b1, reg_idx_t'(i), val);
		end
		for (int i = REG_TRUST_MAX; i <= REG_GAIN_HIGH; i++) begin
			apb_access(1'b0, reg_idx_t'(i), '0);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Result side: random stalls, stretches of steady ready, and one long
	// hold-off on request from the stimulus.
	initial begin : receiver
		int   stay;
		logic held;
		stay = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req && !held) begin
				out_ready <= 1'b0;
				held = 1'b1;
				stay = HOLD_OFF_CYCLES - 1;
			end else if (stay > 0) begin
				stay--;
			end else if (out_ready) begin
				stay = rand_gap();
				if (stay > 0) begin
					out_ready <= 1'b0;
					stay--;
				end
			end else begin
				out_ready <= 1'b1;
				stay = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 8);
			end
		end
	end

	initial begin : stimulus
		cfg_t   s;
		trend_t trend;
		int     run_left;
		int     pick;
		int     gap;
		run_left = 0;
		trend = TREND_ANY;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: far codes, an untrusted code, midscale, one below
		// midscale and the exact trust limit.
		send_sample(12'hFFF, 12'h000, 12'h000, 12'h000, rand_gap());
		send_sample(12'h000, 12'hFFF, 12'hFFF, 12'hFFF, rand_gap());
		send_sample(12'hAAA, 12'h555, 12'hAAA, 12'd2048, rand_gap());
		send_sample(12'h555, 12'h000, 12'h000, 12'd2047, rand_gap());
		send_sample(12'd1, 12'h000, 12'h000, 12'd4000, rand_gap());
		send_sample(12'd2, 12'h000, 12'h000, 12'd3999, rand_gap());
		drain();

		// Widest gains and thresholds, single-hit stepping: walk down to the
		// low range and past it, then back up through untrusted samples.
		s = '{trust_max: '1, over_threshold: 12'd2048, under_threshold: 12'd2048,
			hold_count: 4'd1, voltage_gain: '1, gain_low: '1, gain_mid: '1, gain_high: '1};
		apply_settings(s);
		send_sample(12'hFFF, 12'h000, 12'h000, 12'd4094, rand_gap());
		send_sample(12'hFFF, 12'h000, 12'h000, 12'h000, rand_gap());
		send_sample(12'h000, 12'h000, 12'd2049, 12'h000, rand_gap());
		send_sample(12'h000, 12'd2048, 12'h000, 12'h000, rand_gap());
		send_sample(12'h000, 12'd4094, 12'h000, 12'h000, rand_gap());
		send_sample(12'h000, 12'hFFF, 12'h000, 12'h000, rand_gap());
		send_sample(12'h000, 12'h000, 12'hFFF, 12'h000, rand_gap());
		send_sample(12'h000, 12'h000, 12'h000, 12'hFFF, rand_gap());
		drain();

		// Everything zero: no sample can be trusted.
		s = '{trust_max: '0, over_threshold: '0, under_threshold: '0,
			hold_count: '0, voltage_gain: '0, gain_low: '0, gain_mid: '0, gain_high: '0};
		apply_settings(s);
		send_sample(12'hFFF, 12'h000, 12'h000, 12'h000, rand_gap());
		send_sample(12'h000, 12'hFFF, 12'hFFF, 12'hFFF, rand_gap());
		drain();

		// Hold count of zero steps on the first hit; tiny gains show the
		// rounding towards minus infinity.
		s = '{trust_max: 12'd2049, over_threshold: '0, under_threshold: 12'd2048,
			hold_count: '0, voltage_gain: 24'd1, gain_low: 32'd1, gain_mid: 32'd2,
			gain_high: 32'd3};
		apply_settings(s);
		send_sample(12'd100, 12'h000, 12'h000, 12'd2048, rand_gap());
		send_sample(12'd100, 12'h000, 12'h000, 12'h000, rand_gap());
		send_sample(12'd100, 12'h000, 12'h000, 12'd1, rand_gap());
		send_sample(12'd100, 12'h000, 12'h000, 12'd2048, rand_gap());
		send_sample(12'd100, 12'h000, 12'd2048, 12'h000, rand_gap());
		send_sample(12'd100, 12'd1, 12'h000, 12'h000, rand_gap());
		drain();

		// Random phases, each with fresh settings.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			s.trust_max = ($urandom_range(0, 3) == 0) ? ADC_BITS'($urandom_range(0, 4095))
				: ADC_BITS'($urandom_range(3600, 4095));
			s.over_threshold = ADC_BITS'($urandom_range(1000, 2048));
			s.under_threshold = ADC_BITS'($urandom_range(0, 400));
			s.hold_count = 4'($urandom_range(1, 6));
			s.voltage_gain = 24'($urandom);
			s.gain_low = $urandom;
			s.gain_mid = $urandom;
			s.gain_high = $urandom;
			// The first two phases pin the gains and hold count to their ends.
			if (p == 0) begin
				s.trust_max = '1;
				s.hold_count = 4'd1;
				s.voltage_gain = '1;
				s.gain_low = '1;
				s.gain_mid = '1;
				s.gain_high = '1;
			end else if (p == 1) begin
				s.hold_count = 4'd15;
				s.voltage_gain = '0;
				s.gain_low = '0;
				s.gain_mid = '0;
				s.gain_high = '0;
			end
			apply_settings(s);
			for (int n = 0; n < PHASE_REQUESTS; n++) begin
				if (run_left == 0) begin
					pick = $urandom_range(0, 9);
					trend = (pick < 4) ? TREND_NEAR : (pick < 7) ? TREND_FAR : TREND_ANY;
					run_left = $urandom_range(1, 24);
				end
				run_left--;
				// In the third phase the receiver holds off while requests
				// keep coming back to back, so the block fills and stalls.
				if (p == 2 && n == 20) begin
					hold_off_req <= 1'b1;
				end
				gap = (p == 2 && n >= 20 && n < 60) ? 0 : rand_gap();
				send_sample(ADC_BITS'($urandom_range(0, 4095)), shape_code(trend),
					shape_code(trend), shape_code(trend), gap);
				if (p == 3 && n == 90) begin
					drain();
				end
			end
			drain();
		end

		// Let the block settle before the verdict.
		repeat (8) @(posedge clk);
		if (failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
